/* rtl/core/si_pkg.sv */
package si_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DEGEN    = 2'd1,
        ST_PARALLEL = 2'd2,
        ST_OUTSIDE  = 2'd3
    } t_status;

    // Per-item condition flags that ride along the pipeline.
    typedef struct packed {
        logic degen;
        logic det_zero;
        logic neg_x;
        logic neg_y;
    } t_flags;

endpackage

/* rtl/core/si_if.sv */
// Input channel: two segments given by their endpoints.
interface si_in_if #(parameter int W = 16) ();
    logic valid;
    logic ready;
    logic signed [W-1:0] first_start_x;
    logic signed [W-1:0] first_start_y;
    logic signed [W-1:0] first_end_x;
    logic signed [W-1:0] first_end_y;
    logic signed [W-1:0] second_start_x;
    logic signed [W-1:0] second_start_y;
    logic signed [W-1:0] second_end_x;
    logic signed [W-1:0] second_end_y;

    modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                    second_start_x, second_start_y, second_end_x, second_end_y,
                    input ready);
    modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  output ready);
endinterface

// Output channel: crossing point and status.
interface si_out_if #(parameter int W = 16) ();
    logic valid;
    logic ready;
    logic signed [W-1:0] cross_x;
    logic signed [W-1:0] cross_y;
    logic [1:0] status;

    modport source (output valid, cross_x, cross_y, status, input ready);
    modport sink (input valid, cross_x, cross_y, status, output ready);
endinterface

/* rtl/core/si_front.sv */
module si_front import si_pkg::*; #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    si_in_if.sink                i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [3*W+2:0]       o_nx,
    output logic [3*W+2:0]       o_ny,
    output logic [2*W+2:0]       o_den,
    output t_flags               o_flags,
    output logic [8*W-1:0]       o_coords
);
    localparam int AW = W + 1;
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam int TW = 2 * W + 2;
    localparam int DW = 2 * W + 3;
    localparam int MW = 3 * W + 2;
    localparam int NW = 3 * W + 3;

    logic [5:1] rdy;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // Stage registers.
    logic [8*W-1:0] r1_co, r2_co, r3_co, r4_co, r5_co;
    logic r1_dg, r2_dg, r3_dg, r4_dg;
    logic signed [AW-1:0] r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [AW-1:0] r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [PW-1:0] r1_p1, r1_p2, r1_p3, r1_p4;
    logic signed [CW-1:0] r2_c1, r2_c2;
    logic signed [TW-1:0] r3_t1, r3_t2;
    logic signed [MW-1:0] r3_mx1, r3_mx2, r3_my1, r3_my2;
    logic signed [DW-1:0] r4_det;
    logic signed [NW-1:0] r4_nx, r4_ny;
    logic [NW-1:0] r5_nx, r5_ny;
    logic [DW-1:0] r5_den;
    t_flags r5_fl;

    // Each stage takes a beat when it is empty or its successor moves.
    assign rdy[5] = !r_v5 || i_ready;
    assign rdy[4] = !r_v4 || rdy[5];
    assign rdy[3] = !r_v3 || rdy[4];
    assign rdy[2] = !r_v2 || rdy[3];
    assign rdy[1] = !r_v1 || rdy[2];
    assign i_in.ready = rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy[1]) r_v1 <= i_in.valid;
            if (rdy[2]) r_v2 <= r_v1;
            if (rdy[3]) r_v3 <= r_v2;
            if (rdy[4]) r_v4 <= r_v3;
            if (rdy[5]) r_v5 <= r_v4;
        end
    end

    // Stage 1: line direction terms and the cross products of each segment.
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_co <= {i_in.second_end_y, i_in.second_end_x,
                      i_in.second_start_y, i_in.second_start_x,
                      i_in.first_end_y, i_in.first_end_x,
                      i_in.first_start_y, i_in.first_start_x};
            r1_dg <= (i_in.first_start_x == i_in.first_end_x &&
                      i_in.first_start_y == i_in.first_end_y) ||
                     (i_in.second_start_x == i_in.second_end_x &&
                      i_in.second_start_y == i_in.second_end_y);
            r1_a1 <= AW'(i_in.first_start_y) - AW'(i_in.first_end_y);
            r1_b1 <= AW'(i_in.first_end_x) - AW'(i_in.first_start_x);
            r1_a2 <= AW'(i_in.second_start_y) - AW'(i_in.second_end_y);
            r1_b2 <= AW'(i_in.second_end_x) - AW'(i_in.second_start_x);
            r1_p1 <= i_in.first_start_x * i_in.first_end_y;
            r1_p2 <= i_in.first_end_x * i_in.first_start_y;
            r1_p3 <= i_in.second_start_x * i_in.second_end_y;
            r1_p4 <= i_in.second_end_x * i_in.second_start_y;
        end
    end

    // Stage 2: line constants C.
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_co <= r1_co;
            r2_dg <= r1_dg;
            r2_a1 <= r1_a1;
            r2_b1 <= r1_b1;
            r2_a2 <= r1_a2;
            r2_b2 <= r1_b2;
            r2_c1 <= CW'(r1_p1) - CW'(r1_p2);
            r2_c2 <= CW'(r1_p3) - CW'(r1_p4);
        end
    end

    // Stage 3: products for the determinant and both numerators.
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_co  <= r2_co;
            r3_dg  <= r2_dg;
            r3_t1  <= r2_a1 * r2_b2;
            r3_t2  <= r2_a2 * r2_b1;
            r3_mx1 <= r2_b1 * r2_c2;
            r3_mx2 <= r2_b2 * r2_c1;
            r3_my1 <= r2_a2 * r2_c1;
            r3_my2 <= r2_a1 * r2_c2;
        end
    end

    // Stage 4: determinant and numerators.
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_co  <= r3_co;
            r4_dg  <= r3_dg;
            r4_det <= DW'(r3_t1) - DW'(r3_t2);
            r4_nx  <= NW'(r3_mx1) - NW'(r3_mx2);
            r4_ny  <= NW'(r3_my1) - NW'(r3_my2);
        end
    end

    // Stage 5: magnitudes for the unsigned divider, signs kept as flags.
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_co  <= r4_co;
            r5_nx  <= r4_nx[NW-1] ? (~$unsigned(r4_nx) + NW'(1)) : $unsigned(r4_nx);
            r5_ny  <= r4_ny[NW-1] ? (~$unsigned(r4_ny) + NW'(1)) : $unsigned(r4_ny);
            r5_den <= r4_det[DW-1] ? (~$unsigned(r4_det) + DW'(1)) : $unsigned(r4_det);
            r5_fl.degen    <= r4_dg;
            r5_fl.det_zero <= (r4_det == '0);
            r5_fl.neg_x    <= r4_nx[NW-1] ^ r4_det[DW-1];
            r5_fl.neg_y    <= r4_ny[NW-1] ^ r4_det[DW-1];
        end
    end

    assign o_valid  = r_v5;
    assign o_nx     = r5_nx;
    assign o_ny     = r5_ny;
    assign o_den    = r5_den;
    assign o_flags  = r5_fl;
    assign o_coords = r5_co;

endmodule

/* rtl/core/si_div.sv */
module si_div import si_pkg::*; #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [3*W+2:0]       i_nx,
    input  logic [3*W+2:0]       i_ny,
    input  logic [2*W+2:0]       i_den,
    input  t_flags               i_flags,
    input  logic [8*W-1:0]       i_coords,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [W+1:0]         o_qx,
    output logic [W+1:0]         o_qy,
    output t_flags               o_flags,
    output logic [8*W-1:0]       o_coords
);
    // One restoring step per stage, quotient bits W+1 down to 0.
    // A set top bit means the quotient is beyond every coordinate.
    localparam int S  = W + 2;
    localparam int NW = 3 * W + 3;
    localparam int DW = 2 * W + 3;
    localparam int LW = NW + 1;
    localparam int QW = W + 2;

    logic            r_v  [S];
    logic [NW-1:0]   r_rx [S];
    logic [NW-1:0]   r_ry [S];
    logic [DW-1:0]   r_d  [S];
    logic [QW-1:0]   r_qx [S];
    logic [QW-1:0]   r_qy [S];
    t_flags          r_fl [S];
    logic [8*W-1:0]  r_co [S];
    logic            rdy  [S+1];

    logic            s_v  [S];
    logic [NW-1:0]   s_rx [S];
    logic [NW-1:0]   s_ry [S];
    logic [DW-1:0]   s_d  [S];
    logic [QW-1:0]   s_qx [S];
    logic [QW-1:0]   s_qy [S];
    t_flags          s_fl [S];
    logic [8*W-1:0]  s_co [S];

    assign rdy[S]  = i_ready;
    assign o_ready = rdy[0];

    assign s_v[0]  = i_valid;
    assign s_rx[0] = i_nx;
    assign s_ry[0] = i_ny;
    assign s_d[0]  = i_den;
    assign s_qx[0] = '0;
    assign s_qy[0] = '0;
    assign s_fl[0] = i_flags;
    assign s_co[0] = i_coords;

    for (genvar j = 0; j < S; j++) begin : g_step
        localparam int STEP = S - 1 - j;
        logic [LW-1:0] dsh;
        logic          ge_x, ge_y;
        logic [NW-1:0] n_rx, n_ry;
        logic [QW-1:0] n_qx, n_qy;

        if (j > 0) begin : g_link
            assign s_v[j]  = r_v[j-1];
            assign s_rx[j] = r_rx[j-1];
            assign s_ry[j] = r_ry[j-1];
            assign s_d[j]  = r_d[j-1];
            assign s_qx[j] = r_qx[j-1];
            assign s_qy[j] = r_qy[j-1];
            assign s_fl[j] = r_fl[j-1];
            assign s_co[j] = r_co[j-1];
        end

        assign rdy[j] = !r_v[j] || rdy[j+1];

        // Trial subtraction of the shifted divisor from both remainders.
        always_comb begin
            dsh  = LW'(s_d[j]) << STEP;
            ge_x = LW'(s_rx[j]) >= dsh;
            ge_y = LW'(s_ry[j]) >= dsh;
            n_rx = ge_x ? NW'(LW'(s_rx[j]) - dsh) : s_rx[j];
            n_ry = ge_y ? NW'(LW'(s_ry[j]) - dsh) : s_ry[j];
            n_qx = s_qx[j];
            n_qy = s_qy[j];
            n_qx[STEP] = ge_x;
            n_qy[STEP] = ge_y;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (rdy[j]) begin
                r_v[j] <= s_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[j]) begin
                r_rx[j] <= n_rx;
                r_ry[j] <= n_ry;
                r_d[j]  <= s_d[j];
                r_qx[j] <= n_qx;
                r_qy[j] <= n_qy;
                r_fl[j] <= s_fl[j];
                r_co[j] <= s_co[j];
            end
        end
    end

    assign o_valid  = r_v[S-1];
    assign o_qx     = r_qx[S-1];
    assign o_qy     = r_qy[S-1];
    assign o_flags  = r_fl[S-1];
    assign o_coords = r_co[S-1];

endmodule

/* rtl/core/si_back.sv */
module si_back import si_pkg::*; #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [W+1:0]         i_qx,
    input  logic [W+1:0]         i_qy,
    input  t_flags               i_flags,
    input  logic [8*W-1:0]       i_coords,
    si_out_if.source             o_out
);
    localparam int QW = W + 2;

    logic signed [QW-1:0] qx, qy;
    logic signed [QW-1:0] c [8];
    logic                 in_bounds;
    t_status              n_st;
    logic                 r_v;
    logic signed [W-1:0]  r_x, r_y;
    t_status              r_st;

    function automatic logic in_span(input logic signed [QW-1:0] v,
                                     input logic signed [QW-1:0] e0,
                                     input logic signed [QW-1:0] e1);
        logic signed [QW-1:0] lo, hi;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        return (v >= lo) && (v <= hi);
    endfunction

    // Signed quotients and the inclusive range tests against both segments.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            c[k] = QW'($signed(i_coords[k*W +: W]));
        end
        qx = i_flags.neg_x ? -$signed({1'b0, i_qx[W:0]}) : $signed({1'b0, i_qx[W:0]});
        qy = i_flags.neg_y ? -$signed({1'b0, i_qy[W:0]}) : $signed({1'b0, i_qy[W:0]});
        in_bounds = !i_qx[W+1] && !i_qy[W+1] &&
                    in_span(qx, c[0], c[2]) && in_span(qy, c[1], c[3]) &&
                    in_span(qx, c[4], c[6]) && in_span(qy, c[5], c[7]);
        if (i_flags.degen) begin
            n_st = ST_DEGEN;
        end else if (i_flags.det_zero) begin
            n_st = ST_PARALLEL;
        end else if (!in_bounds) begin
            n_st = ST_OUTSIDE;
        end else begin
            n_st = ST_OK;
        end
    end

    // Output register.
    assign o_ready = !r_v || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_st <= n_st;
            r_x  <= (n_st == ST_OK) ? qx[W-1:0] : '0;
            r_y  <= (n_st == ST_OK) ? qy[W-1:0] : '0;
        end
    end

    assign o_out.valid   = r_v;
    assign o_out.cross_x = r_x;
    assign o_out.cross_y = r_y;
    assign o_out.status  = r_st;

endmodule

/* rtl/core/segment_intersection.sv */
// Segment intersection: takes two segments as signed fixed point endpoints and
// returns their crossing point with a status (ok, degenerate segment, parallel
// lines, or point outside a segment); the point is zero unless the status is ok.
// One beat is accepted per cycle when the output is not stalled. Each beat passes
// a pipeline of multiply and subtract for the line coefficients, determinant and
// numerators, a pipelined restoring division over COORD_BITS + 2 quotient bits,
// and the range tests into the output register.
module segment_intersection import si_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    si_in_if.sink      i_in,
    si_out_if.source   o_out
);
    localparam int W = COORD_BITS;

    logic             f_valid, f_ready;
    logic [3*W+2:0]   f_nx, f_ny;
    logic [2*W+2:0]   f_den;
    t_flags           f_flags;
    logic [8*W-1:0]   f_co;

    logic             d_valid, d_ready;
    logic [W+1:0]     d_qx, d_qy;
    t_flags           d_flags;
    logic [8*W-1:0]   d_co;

    si_front #(.W(W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_nx     (f_nx),
        .o_ny     (f_ny),
        .o_den    (f_den),
        .o_flags  (f_flags),
        .o_coords (f_co)
    );

    si_div #(.W(W)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .o_ready  (f_ready),
        .i_nx     (f_nx),
        .i_ny     (f_ny),
        .i_den    (f_den),
        .i_flags  (f_flags),
        .i_coords (f_co),
        .o_valid  (d_valid),
        .i_ready  (d_ready),
        .o_qx     (d_qx),
        .o_qy     (d_qy),
        .o_flags  (d_flags),
        .o_coords (d_co)
    );

    si_back #(.W(W)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (d_valid),
        .o_ready  (d_ready),
        .i_qx     (d_qx),
        .i_qy     (d_qy),
        .i_flags  (d_flags),
        .i_coords (d_co),
        .o_out    (o_out)
    );

endmodule

/* rtl/core/si_check.sv */
module si_check import si_pkg::*; #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_ready,
    input  logic [W-1:0] i_cross_x,
    input  logic [W-1:0] i_cross_y,
    input  logic [1:0]   i_status
);

    // A beat that is not ok carries a zero point.
    a_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status != ST_OK) |-> (i_cross_x == '0 && i_cross_y == '0))
        else $error("non-ok result with nonzero point");

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result beat right after reset");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable(i_cross_x) && $stable(i_cross_y) && $stable(i_status)))
        else $error("stalled result beat changed");

endmodule

bind segment_intersection si_check #(.W(COORD_BITS)) u_si_check (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_out.valid),
    .i_ready   (o_out.ready),
    .i_cross_x (o_out.cross_x),
    .i_cross_y (o_out.cross_y),
    .i_status  (o_out.status)
);

/* tb/segment_intersection_checker.sv */
`timescale 1ns / 100ps

// Watches both channels, predicts each crossing result and compares it.
module segment_intersection_checker import si_pkg::*; #(
    parameter int W = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    si_in_if.sink    i_in_mon,
    si_out_if.sink   i_out_mon,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_status_seen [4]
);

    typedef struct {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        t_status             st;
    } t_cross;

    t_cross expected_crossings[$];
    int     mismatch_count;

    // Coordinate range check, inclusive at both ends.
    function automatic bit between(longint v, longint e0, longint e1);
        longint lo;
        longint hi;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        return (v >= lo) && (v <= hi);
    endfunction

    // Truncated quotient; returns 0 when the magnitude exceeds 2**W.
    function automatic bit quotient_fits(logic signed [127:0] num, longint den,
                                         output longint q);
        logic signed [127:0] qq;
        logic [127:0]        mag;
        qq = num / 128'(signed'(den));
        mag = qq[127] ? -qq : qq;
        q = longint'(qq);
        return mag <= (128'd1 << W);
    endfunction

    // Solves the two supporting lines by Cramer's rule.
    function automatic t_cross crossing_of(longint x0, longint y0, longint x1, longint y1,
                                           longint u0, longint v0, longint u1, longint v1);
        t_cross              r;
        longint              a1, b1, c1, a2, b2, c2, det, qx, qy;
        logic signed [127:0] nx, ny;
        r.px = '0;
        r.py = '0;
        r.st = ST_OK;
        if ((x0 == x1 && y0 == y1) || (u0 == u1 && v0 == v1)) begin
            r.st = ST_DEGEN;
        end else begin
            a1 = y0 - y1; b1 = x1 - x0; c1 = x0 * y1 - x1 * y0;
            a2 = v0 - v1; b2 = u1 - u0; c2 = u0 * v1 - u1 * v0;
            det = a1 * b2 - a2 * b1;
            if (det == 0) begin
                r.st = ST_PARALLEL;
            end else begin
                nx = 128'(signed'(b1)) * c2 - 128'(signed'(b2)) * c1;
                ny = 128'(signed'(a2)) * c1 - 128'(signed'(a1)) * c2;
                if (!quotient_fits(nx, det, qx) || !quotient_fits(ny, det, qy) ||
                    !between(qx, x0, x1) || !between(qy, y0, y1) ||
                    !between(qx, u0, u1) || !between(qy, v0, v1)) begin
                    r.st = ST_OUTSIDE;
                end else begin
                    r.px = W'(qx);
                    r.py = W'(qy);
                end
            end
        end
        return r;
    endfunction

    assign o_fail_count = mismatch_count;
    assign o_pending = expected_crossings.size();

    // Predict on input beats, compare on output beats.
    always @(posedge i_clk) begin
        t_cross want;
        if (i_rst_n && i_in_mon.valid && i_in_mon.ready) begin
            expected_crossings.push_back(crossing_of(
                i_in_mon.first_start_x, i_in_mon.first_start_y,
                i_in_mon.first_end_x, i_in_mon.first_end_y,
                i_in_mon.second_start_x, i_in_mon.second_start_y,
                i_in_mon.second_end_x, i_in_mon.second_end_y));
        end
        if (i_rst_n && i_out_mon.valid && i_out_mon.ready) begin
            if (expected_crossings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output beat: x=%0d y=%0d status=%0d",
                             i_out_mon.cross_x, i_out_mon.cross_y, i_out_mon.status);
            end else begin
                want = expected_crossings.pop_front();
                o_status_seen[want.st]++;
                if (i_out_mon.cross_x !== want.px || i_out_mon.cross_y !== want.py ||
                    i_out_mon.status !== want.st) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                                 want.px, want.py, want.st, i_out_mon.cross_x,
                                 i_out_mon.cross_y, i_out_mon.status);
                end
            end
        end
    end

    initial begin
        mismatch_count = 0;
        foreach (o_status_seen[k]) o_status_seen[k] = 0;
    end

endmodule

/* tb/segment_intersection_test.sv */
`timescale 1ns / 100ps

// Drives segment pairs into the block and gives the verdict.
module segment_intersection_test;
    import si_pkg::*;

    localparam int W = 16;
    localparam int RANDOM_BEATS = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 3 * (W + 8);

    typedef logic signed [W-1:0] t_coord;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;
    int   status_seen [4];

    si_in_if  #(.W(W)) seg_in ();
    si_out_if #(.W(W)) cross_out ();

    segment_intersection #(.COORD_BITS(W)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(seg_in.sink), .o_out(cross_out.source)
    );

    segment_intersection_checker #(.W(W)) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_mon(seg_in.sink),
        .i_out_mon(cross_out.sink), .o_fail_count(fail_count), .o_pending(pending),
        .o_status_seen(status_seen)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("segment_intersection_test: done, errors");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver stalls at random, with quiet stretches of full throughput.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cross_out.ready <= 1'b0;
        end else if ((cycle_count / 2000) % 3 == 2) begin
            cross_out.ready <= 1'b1;
        end else begin
            cross_out.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // Holds one beat until accepted, then optionally idles.
    task automatic send_pair(t_coord c[8]);
        int g;
        seg_in.valid <= 1'b1;
        seg_in.first_start_x <= c[0];
        seg_in.first_start_y <= c[1];
        seg_in.first_end_x <= c[2];
        seg_in.first_end_y <= c[3];
        seg_in.second_start_x <= c[4];
        seg_in.second_start_y <= c[5];
        seg_in.second_end_x <= c[6];
        seg_in.second_end_y <= c[7];
        do @(posedge i_clk); while (!seg_in.ready);
        g = ((cycle_count / 2000) % 3 == 2) ? 0 : gap_len();
        if (g > 0) begin
            seg_in.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic t_coord any_coord();
        case ($urandom_range(0, 5))
            0: return t_coord'(16'h8000);
            1: return t_coord'(16'h7FFF);
            2: return t_coord'($urandom_range(0, 40)) - 20;
            default: return t_coord'($urandom());
        endcase
    endfunction

    initial begin
        t_coord c[8];
        t_coord p, q;
        int kind;
        seg_in.valid = 1'b0;
        seg_in.first_start_x = '0; seg_in.first_start_y = '0;
        seg_in.first_end_x = '0;   seg_in.first_end_y = '0;
        seg_in.second_start_x = '0; seg_in.second_start_y = '0;
        seg_in.second_end_x = '0;   seg_in.second_end_y = '0;
        cross_out.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plain crossing, each degenerate side, parallel, collinear,
        // outside, extremes, and a huge quotient from nearly parallel lines.
        c = '{-160, 0, 160, 0, 0, -160, 0, 160};           send_pair(c);
        c = '{5, 5, 5, 5, 0, 0, 16, 16};                   send_pair(c);
        c = '{0, 0, 16, 16, -7, 3, -7, 3};                 send_pair(c);
        c = '{0, 0, 16, 16, 0, 16, 16, 32};                send_pair(c);
        c = '{0, 0, 16, 16, 32, 32, 48, 48};               send_pair(c);
        c = '{0, 0, 16, 0, 100, -16, 100, 16};             send_pair(c);
        c = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768};
        send_pair(c);
        c = '{-32768, 0, 32767, 0, 0, -32768, 0, 32767};   send_pair(c);
        c = '{-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767};
        send_pair(c);
        c = '{0, 0, 1, 0, 0, 1, 32767, 0};                 send_pair(c);
        c = '{0, 0, 3, 7, 3, 0, 0, 7};                     send_pair(c);
        c = '{-1, -1, -1, -1, -1, -1, -1, -1};             send_pair(c);
        c = '{32767, -32768, -32768, 32767, 0, 0, 1, 1};   send_pair(c);

        // Pause until the pipeline has drained completely.
        seg_in.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        // Random: half of the pairs built to cross, the rest parallel, degenerate or arbitrary.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                // Center both segments near a shared point so that they usually cross.
                p = t_coord'($urandom_range(0, 4000)) - 2000;
                q = t_coord'($urandom_range(0, 4000)) - 2000;
                c[0] = p - t_coord'($urandom_range(0, 900));
                c[1] = q - t_coord'($urandom_range(0, 900));
                c[2] = p + (p - c[0]);
                c[3] = q + (q - c[1]);
                c[4] = p + t_coord'($urandom_range(0, 900));
                c[5] = q - t_coord'($urandom_range(0, 900));
                c[6] = p - (c[4] - p) + t_coord'($urandom_range(0, 4));
                c[7] = q + (q - c[5]);
            end else if (kind == 5) begin
                foreach (c[k]) c[k] = any_coord();
                c[2] = c[0] + 16 * t_coord'($urandom_range(1, 5));
                c[3] = c[1] + 16 * t_coord'($urandom_range(1, 5));
                c[4] = c[0] - 3; c[5] = c[1] + 7;
                c[6] = c[4] + (c[2] - c[0]) * 2; c[7] = c[5] + (c[3] - c[1]) * 2;
            end else if (kind == 6) begin
                foreach (c[k]) c[k] = any_coord();
                if ($urandom_range(0, 1)) begin
                    c[2] = c[0]; c[3] = c[1];
                end else begin
                    c[6] = c[4]; c[7] = c[5];
                end
            end else begin
                foreach (c[k]) c[k] = any_coord();
            end
            send_pair(c);
        end
        seg_in.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d random segment pairs plus directed corners", RANDOM_BEATS);
        $display("statuses seen: ok %0d, degenerate %0d, parallel %0d, outside %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0) begin
            $display("segment_intersection_test: done, clean");
        end else begin
            $display("segment_intersection_test: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/si_pkg.sv
rtl/core/si_if.sv
rtl/core/si_front.sv
rtl/core/si_div.sv
rtl/core/si_back.sv
rtl/core/segment_intersection.sv
rtl/core/si_check.sv
tb/segment_intersection_checker.sv
tb/segment_intersection_test.sv
